@@ design/fdd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the frame change detector.
// No dependencies; fdd_cfg, fdd_outq and frame_diff_dirty_rect import this package.
package fdd_pkg;

    localparam int CFG_DIM_W   = 11;
    localparam int ADDR_W      = 20;
    localparam int PIX_W       = 32;
    localparam int RECT_W      = 10;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;
    localparam int OUTQ_DEPTH  = 8;
    localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);

    localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST = 11'd1024;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ROTATE_MODE  = 2'd2;

    // Result kinds
    localparam logic RK_PIXEL_WRITE = 1'b0;
    localparam logic RK_DIRTY_RECT  = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
    } t_pixel_in;

    typedef struct packed {
        logic              result_kind;
        logic [ADDR_W-1:0] remote_address;
        logic [PIX_W-1:0]  remote_pixel;
        logic [RECT_W-1:0] rect_min_x;
        logic [RECT_W-1:0] rect_min_y;
        logic [RECT_W-1:0] rect_max_x;
        logic [RECT_W-1:0] rect_max_y;
        logic              run_last;
    } t_result;

    typedef struct packed {
        logic [CFG_DIM_W-1:0] frame_width;
        logic [CFG_DIM_W-1:0] frame_height;
        logic                 rotate_mode;
    } t_cfg;

endpackage

@@ design/fdd_stream_if.sv @@
`timescale 1ns / 1ps
// Valid/ready stream channel with a typed payload.
// Used for the pixel input and the result output of the detector.
interface fdd_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ design/fdd_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read during write to the same address returns the old contents.
module fdd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/fdd_cfg.sv @@
`timescale 1ns / 1ps
// APB register file: frame width, frame height, rotate mode.
// Depends on fdd_pkg; flags a frame restart on every write to a listed register.
module fdd_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fdd_pkg::PADDR_W-1:0]  paddr,
    input  logic [fdd_pkg::PDATA_W-1:0]  pwdata,
    output logic [fdd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output fdd_pkg::t_cfg                o_cfg,
    output logic                         o_restart
);
    import fdd_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       w_write;
    logic       w_hit;
    logic [1:0] w_idx;

    assign w_write = psel && penable && pwrite;
    assign w_idx   = paddr[3:2];

    always_comb begin
        n_cfg = r_cfg;
        w_hit = 1'b0;
        unique case (w_idx)
            REG_FRAME_WIDTH: begin
                n_cfg.frame_width = pwdata[CFG_DIM_W-1:0];
                w_hit = 1'b1;
            end
            REG_FRAME_HEIGHT: begin
                n_cfg.frame_height = pwdata[CFG_DIM_W-1:0];
                w_hit = 1'b1;
            end
            REG_ROTATE_MODE: begin
                n_cfg.rotate_mode = pwdata[0];
                w_hit = 1'b1;
            end
            default: begin
                w_hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= FRAME_WIDTH_RST;
            r_cfg.frame_height <= FRAME_HEIGHT_RST;
            r_cfg.rotate_mode  <= 1'b0;
        end else if (w_write && w_hit) begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(r_cfg.frame_width);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(r_cfg.frame_height);
            REG_ROTATE_MODE:  prdata = PDATA_W'(r_cfg.rotate_mode);
            default:          prdata = '0;
        endcase
    end

    assign pready    = 1'b1;
    assign o_cfg     = r_cfg;
    // Same edge as the write: the counters see it before the next pixel.
    assign o_restart = w_write && w_hit;
endmodule

@@ design/fdd_outq.sv @@
`timescale 1ns / 1ps
// Result queue: takes up to two results a cycle, hands out one per request.
// Depends on fdd_pkg and fdd_stream_if.
module fdd_outq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push_a,
    input  fdd_pkg::t_result               i_data_a,
    input  logic                           i_push_b,
    input  fdd_pkg::t_result               i_data_b,
    fdd_stream_if.source                   o_res,
    output logic [fdd_pkg::OUTQ_CNT_W-1:0] o_count
);
    import fdd_pkg::*;

    t_result               r_q [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] r_wp;
    logic [OUTQ_PTR_W-1:0] r_rp;
    logic [OUTQ_CNT_W-1:0] r_count;
    logic [OUTQ_PTR_W-1:0] n_wp;
    logic [OUTQ_CNT_W-1:0] n_count;
    logic                  w_pop;

    assign o_res.valid   = (r_count != '0);
    assign o_res.payload = r_q[r_rp];
    assign w_pop         = o_res.valid && o_res.ready;
    assign o_count       = r_count;

    assign n_wp    = r_wp + OUTQ_PTR_W'(i_push_a) + OUTQ_PTR_W'(i_push_b);
    assign n_count = r_count + OUTQ_CNT_W'(i_push_a) + OUTQ_CNT_W'(i_push_b)
                   - OUTQ_CNT_W'(w_pop);

    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_q[r_wp] <= i_data_a;
        end
        if (i_push_b) begin
            r_q[r_wp + OUTQ_PTR_W'(1)] <= i_data_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_count <= n_count;
            if (w_pop) begin
                r_rp <= r_rp + OUTQ_PTR_W'(1);
            end
        end
    end
endmodule

@@ design/frame_diff_dirty_rect.sv @@
`timescale 1ns / 1ps
// Frame change detector with dirty-rectangle tracking.
// Throughput: one pixel per cycle while not clearing and the result queue has room; one read
// and at most one write of the store per pixel; results pass the store read, then the queue.
// Reset: synchronous; the store is then zeroed one word a cycle, all MAX_WIDTH*MAX_HEIGHT words
// (1048576 at defaults), with no pixel requests taken meanwhile; register writes are taken.
module frame_diff_dirty_rect #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fdd_pkg::PADDR_W-1:0]  paddr,
    input  logic [fdd_pkg::PDATA_W-1:0]  pwdata,
    output logic [fdd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    fdd_stream_if.sink                   i_pix,
    fdd_stream_if.source                 o_res
);
    import fdd_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int SW    = CW + 1;
    localparam int SH    = RW + 1;
    localparam int BW    = (CW > RW) ? CW : RW;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = CW + SH;
    localparam int RST_W = (int'(FRAME_WIDTH_RST) > MAX_WIDTH) ? MAX_WIDTH
                                                               : int'(FRAME_WIDTH_RST);
    localparam int RST_H = (int'(FRAME_HEIGHT_RST) > MAX_HEIGHT) ? MAX_HEIGHT
                                                                 : int'(FRAME_HEIGHT_RST);

    t_cfg                  w_cfg;
    logic                  w_restart;
    logic [SW-1:0]         w_w;
    logic [SH-1:0]         w_h;
    logic [BW-1:0]         w_box_x0;
    logic [BW-1:0]         w_box_y0;

    logic                  r_clearing;
    logic [AW-1:0]         r_clr_addr;

    logic [CW-1:0]         r_col;
    logic [RW-1:0]         r_row;
    logic [AW-1:0]         r_idx;
    logic [CW-1:0]         n_col;
    logic [RW-1:0]         n_row;
    logic [AW-1:0]         n_idx;
    logic                  w_col_last;
    logic                  w_row_last;
    logic                  w_accept;
    logic [OUTQ_CNT_W-1:0] w_q_count;
    logic [SH-1:0]         w_x2r;
    logic [PW-1:0]         w_rot_addr;

    logic                  r_s1_valid;
    logic                  r_s1_first;
    logic                  r_s1_last;
    logic [PIX_W-1:0]      r_s1_pix;
    logic [AW-1:0]         r_s1_idx;
    logic [ADDR_W-1:0]     r_s1_addr;
    logic [BW-1:0]         r_s1_x;
    logic [BW-1:0]         r_s1_y;
    logic                  r_s1_fwd;
    logic [PIX_W-1:0]      r_s1_fwd_pix;

    logic [BW-1:0]         r_min_x;
    logic [BW-1:0]         r_min_y;
    logic [BW-1:0]         r_max_x;
    logic [BW-1:0]         r_max_y;
    logic                  r_any;
    logic [BW-1:0]         n_min_x;
    logic [BW-1:0]         n_min_y;
    logic [BW-1:0]         n_max_x;
    logic [BW-1:0]         n_max_y;
    logic                  n_any;

    logic [PIX_W-1:0]      w_rdata;
    logic [PIX_W-1:0]      w_old;
    logic                  w_changed;
    logic                  w_rect;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [PIX_W-1:0]      w_wdata;
    t_result               w_res_wr;
    t_result               w_res_rect;
    logic                  w_push_a;
    logic                  w_push_b;
    t_result               w_data_a;

    fdd_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (w_cfg),
        .o_restart (w_restart)
    );

    // Clamp sizes to 1..MAX.
    always_comb begin
        if (w_cfg.frame_width == '0) begin
            w_w = SW'(1);
        end else if (int'(w_cfg.frame_width) > MAX_WIDTH) begin
            w_w = SW'(MAX_WIDTH);
        end else begin
            w_w = SW'(w_cfg.frame_width);
        end
        if (w_cfg.frame_height == '0) begin
            w_h = SH'(1);
        end else if (int'(w_cfg.frame_height) > MAX_HEIGHT) begin
            w_h = SH'(MAX_HEIGHT);
        end else begin
            w_h = SH'(w_cfg.frame_height);
        end
    end

    assign w_box_x0 = w_cfg.rotate_mode ? BW'(w_h - SH'(1)) : BW'(w_w - SW'(1));
    assign w_box_y0 = w_cfg.rotate_mode ? BW'(w_w - SW'(1)) : BW'(w_h - SH'(1));

    // Zero the store after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Stage 0: raster counters and store read.
    assign i_pix.ready = !r_clearing && (w_q_count <= OUTQ_CNT_W'(OUTQ_DEPTH - 4));
    assign w_accept    = i_pix.valid && i_pix.ready;
    assign w_col_last  = (SW'(r_col) + SW'(1)) >= w_w;
    assign w_row_last  = (SH'(r_row) + SH'(1)) >= w_h;

    always_comb begin
        n_col = r_col + CW'(1);
        n_row = r_row;
        n_idx = r_idx + AW'(1);
        if (w_col_last) begin
            n_col = '0;
            if (w_row_last) begin
                n_row = '0;
                n_idx = '0;
            end else begin
                n_row = r_row + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_idx <= '0;
        end else if (w_restart) begin
            r_col <= '0;
            r_row <= '0;
            r_idx <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
            r_idx <= n_idx;
        end
    end

    assign w_x2r      = w_h - SH'(1) - SH'(r_row);
    assign w_rot_addr = PW'(r_col) * PW'(w_h) + PW'(w_x2r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_first <= (r_col == '0) && (r_row == '0);
            r_s1_last  <= w_col_last && w_row_last;
            r_s1_pix   <= i_pix.payload.pixel_value;
            r_s1_idx   <= r_idx;
            if (w_cfg.rotate_mode) begin
                r_s1_addr <= ADDR_W'(w_rot_addr);
                r_s1_x    <= BW'(w_x2r);
                r_s1_y    <= BW'(r_col);
            end else begin
                r_s1_addr <= ADDR_W'(r_idx);
                r_s1_x    <= BW'(r_col);
                r_s1_y    <= BW'(r_row);
            end
            // The entry stage 1 writes at this edge is read stale: forward it.
            r_s1_fwd     <= r_s1_valid && (r_s1_idx == r_idx);
            r_s1_fwd_pix <= r_s1_pix;
        end
    end

    fdd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // Stage 1: compare, write back, grow the box.
    assign w_old     = r_s1_fwd ? r_s1_fwd_pix : w_rdata;
    assign w_changed = r_s1_valid && (w_old != r_s1_pix);
    assign w_we      = r_clearing || w_changed;
    assign w_waddr   = r_clearing ? r_clr_addr : r_s1_idx;
    assign w_wdata   = r_clearing ? '0 : r_s1_pix;

    always_comb begin
        n_min_x = r_s1_first ? w_box_x0 : r_min_x;
        n_min_y = r_s1_first ? w_box_y0 : r_min_y;
        n_max_x = r_s1_first ? '0 : r_max_x;
        n_max_y = r_s1_first ? '0 : r_max_y;
        n_any   = r_s1_first ? 1'b0 : r_any;
        if (w_changed) begin
            if (r_s1_x < n_min_x) n_min_x = r_s1_x;
            if (r_s1_x > n_max_x) n_max_x = r_s1_x;
            if (r_s1_y < n_min_y) n_min_y = r_s1_y;
            if (r_s1_y > n_max_y) n_max_y = r_s1_y;
            n_any = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= BW'(RST_W - 1);
            r_min_y <= BW'(RST_H - 1);
            r_max_x <= '0;
            r_max_y <= '0;
            r_any   <= 1'b0;
        end else if (r_s1_valid) begin
            r_min_x <= n_min_x;
            r_min_y <= n_min_y;
            r_max_x <= n_max_x;
            r_max_y <= n_max_y;
            r_any   <= n_any;
        end
    end

    assign w_rect = r_s1_valid && r_s1_last && n_any;

    always_comb begin
        w_res_wr                = '0;
        w_res_wr.result_kind    = RK_PIXEL_WRITE;
        w_res_wr.remote_address = r_s1_addr;
        w_res_wr.remote_pixel   = r_s1_pix;
        w_res_wr.run_last       = !w_rect;

        w_res_rect             = '0;
        w_res_rect.result_kind = RK_DIRTY_RECT;
        w_res_rect.rect_min_x  = RECT_W'(n_min_x);
        w_res_rect.rect_min_y  = RECT_W'(n_min_y);
        w_res_rect.rect_max_x  = RECT_W'(n_max_x);
        w_res_rect.rect_max_y  = RECT_W'(n_max_y);
        w_res_rect.run_last    = 1'b1;
    end

    // Write goes first; the rectangle takes the first slot when nothing changed.
    assign w_push_a = w_changed || w_rect;
    assign w_push_b = w_changed && w_rect;
    assign w_data_a = w_changed ? w_res_wr : w_res_rect;

    fdd_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (w_push_a),
        .i_data_a (w_data_a),
        .i_push_b (w_push_b),
        .i_data_b (w_res_rect),
        .o_res    (o_res),
        .o_count  (w_q_count)
    );

`ifndef SYNTHESIS
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_count <= OUTQ_CNT_W'(OUTQ_DEPTH))
        else $error("result queue overflow");

    a_frame_end_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_last |-> (r_col == '0) && (r_row == '0))
        else $error("counters not wrapped at frame end");

    a_fwd_needs_prior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_fwd |-> $past(r_s1_valid))
        else $error("forward without a prior store write slot");

    a_no_work_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_s1_valid)
        else $error("pixel in flight during store clear");
`endif
endmodule
